### rtl/mmc_command_frame_builder_top_defines.svh
//------------------------------------------------------------------------------
// mmc_command_frame_builder_top_defines.svh
// Assertion macros used by the frame builder checker.
//------------------------------------------------------------------------------
`ifndef MMC_COMMAND_FRAME_BUILDER_TOP_DEFINES_SVH
`define MMC_COMMAND_FRAME_BUILDER_TOP_DEFINES_SVH

// Concurrent assertion, clocked on rising edge, disabled while reset is low.
`define MMCFB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Implication form: antecedent holds, consequent must hold on the next edge.
`define MMCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mmcfb_pkg.sv
//------------------------------------------------------------------------------
// mmcfb_pkg
// Types, constants and CRC7 helpers for the MMC command frame builder.
//------------------------------------------------------------------------------
package mmcfb_pkg;

	localparam int unsigned IDX_W      = 6;
	localparam int unsigned ARG_W      = 32;
	localparam int unsigned CRC_W      = 7;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned FRAME_LEN  = 7;
	localparam int unsigned POS_W      = 3;
	localparam int unsigned S_TDATA_W  = 40;
	// one CRC stage per covered byte: header, then four argument bytes
	localparam int unsigned CRC_STAGES = 5;

	// frame positions
	localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
	localparam logic [POS_W-1:0] POS_CRC   = 3'd5;
	localparam logic [POS_W-1:0] POS_LAST  = 3'd6;

	// start bit 0, transmission bit 1
	localparam logic [1:0] START_TX_BITS = 2'b01;

	// command indexes with a dedicated control byte
	localparam logic [IDX_W-1:0] CMD_ALL_SEND_CID = 6'd2;
	localparam logic [IDX_W-1:0] CMD_SEND_CSD     = 6'd9;
	localparam logic [IDX_W-1:0] CMD_READ_SINGLE  = 6'd17;
	localparam logic [IDX_W-1:0] CMD_WRITE_BLOCK  = 6'd24;

	// control byte codes
	localparam logic [BYTE_W-1:0] CTRL_REG_READ  = 8'd9;
	localparam logic [BYTE_W-1:0] CTRL_BLK_READ  = 8'd3;
	localparam logic [BYTE_W-1:0] CTRL_BLK_WRITE = 8'd5;
	localparam logic [BYTE_W-1:0] CTRL_PLAIN     = 8'd1;

	// x^7 + x^3 + 1, low terms
	localparam logic [CRC_W-1:0] CRC7_POLY = 7'h09;

	typedef struct packed {
		logic [IDX_W-1:0] cmd_index;
		logic [ARG_W-1:0] argument;
		logic [CRC_W-1:0] crc;
	} cmd_item_t;

	// fold one byte, MSB first, into a CRC7 register
	function automatic logic [CRC_W-1:0] crc7_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		logic fb;
		c = crc_in;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = c[CRC_W-1] ^ data[i];
			c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC7_POLY : '0);
		end
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] ctrl_byte(input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] r;
		case (idx) inside
			CMD_ALL_SEND_CID, CMD_SEND_CSD: r = CTRL_REG_READ;
			CMD_READ_SINGLE:                r = CTRL_BLK_READ;
			CMD_WRITE_BLOCK:                r = CTRL_BLK_WRITE;
			default:                        r = CTRL_PLAIN;
		endcase
		return r;
	endfunction

endpackage

### rtl/mmcfb_crc_stage.sv
//------------------------------------------------------------------------------
// mmcfb_crc_stage
// One pipeline stage: folds one frame byte into the running CRC7.
//------------------------------------------------------------------------------
module mmcfb_crc_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mmcfb_pkg::cmd_item_t              in_item,
	input  logic [mmcfb_pkg::BYTE_W-1:0]      fold_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mmcfb_pkg::cmd_item_t              out_item
);

	logic                 valid_s1;
	mmcfb_pkg::cmd_item_t item_s1;

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.cmd_index <= in_item.cmd_index;
			item_s1.argument  <= in_item.argument;
			item_s1.crc       <= mmcfb_pkg::crc7_byte(in_item.crc, fold_byte);
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

### rtl/mmcfb_serializer.sv
//------------------------------------------------------------------------------
// mmcfb_serializer
// Loads a finished command and sends its seven frame bytes in order.
//------------------------------------------------------------------------------
module mmcfb_serializer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mmcfb_pkg::cmd_item_t              in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mmcfb_pkg::BYTE_W-1:0]      out_byte,
	output logic                              out_last
);

	logic [mmcfb_pkg::BYTE_W-1:0] bytes_q [mmcfb_pkg::FRAME_LEN];
	logic [mmcfb_pkg::POS_W-1:0]  pos_q;
	logic                         busy_q;
	logic                         last_xfer;

	assign out_last  = (pos_q == mmcfb_pkg::POS_LAST);
	assign last_xfer = busy_q && out_ready && out_last;
	// next frame loads in the same cycle the last byte leaves
	assign in_ready  = !busy_q || last_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= mmcfb_pkg::POS_FIRST;
		end else if (in_ready) begin
			busy_q <= in_valid;
			pos_q  <= mmcfb_pkg::POS_FIRST;
		end else if (busy_q && out_ready) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bytes_q[0] <= {mmcfb_pkg::START_TX_BITS, in_item.cmd_index};
			bytes_q[1] <= in_item.argument[31:24];
			bytes_q[2] <= in_item.argument[23:16];
			bytes_q[3] <= in_item.argument[15:8];
			bytes_q[4] <= in_item.argument[7:0];
			bytes_q[5] <= {in_item.crc, 1'b1};
			bytes_q[6] <= mmcfb_pkg::ctrl_byte(in_item.cmd_index);
		end
	end

	assign out_valid = busy_q;
	assign out_byte  = bytes_q[pos_q];

endmodule

### rtl/mmc_command_frame_builder_top.sv
//------------------------------------------------------------------------------
// mmc_command_frame_builder_top
// m_axis_tvalid rises once a command has passed the five CRC stage registers
// and has been loaded into the serializer; the first byte can then transfer.
// Each command leaves as seven bytes on the byte-wide output port;
// the five CRC stages take a new command every cycle while room is left.
// Reset (arst_n low, asynchronous) empties every stage and the serializer.
//------------------------------------------------------------------------------
module mmc_command_frame_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [5:0] cmd_index, [37:6] argument, [39:38] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] frame_byte
	output logic        m_axis_tlast   // last_byte
);

	// stage chain: index 0 is the input port, index k the output of stage k
	logic                 vld   [mmcfb_pkg::CRC_STAGES+1];
	logic                 rdy   [mmcfb_pkg::CRC_STAGES+1];
	mmcfb_pkg::cmd_item_t item  [mmcfb_pkg::CRC_STAGES+1];
	logic [7:0]           fold  [mmcfb_pkg::CRC_STAGES];

	assign vld[0]            = s_axis_tvalid;
	assign s_axis_tready     = rdy[0];
	assign item[0].cmd_index = s_axis_tdata[5:0];
	assign item[0].argument  = s_axis_tdata[37:6];
	assign item[0].crc       = '0;   // zero seed

	// byte folded in by each stage: header, then argument MSB first
	assign fold[0] = {mmcfb_pkg::START_TX_BITS, item[0].cmd_index};
	assign fold[1] = item[1].argument[31:24];
	assign fold[2] = item[2].argument[23:16];
	assign fold[3] = item[3].argument[15:8];
	assign fold[4] = item[4].argument[7:0];

	for (genvar k = 0; k < mmcfb_pkg::CRC_STAGES; k++) begin : g_crc
		mmcfb_crc_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[k]),
			.in_ready  (rdy[k]),
			.in_item   (item[k]),
			.fold_byte (fold[k]),
			.out_valid (vld[k+1]),
			.out_ready (rdy[k+1]),
			.out_item  (item[k+1])
		);
	end

	// after stage 5 the CRC covers bytes 0..4; the serializer owns the frame
	mmcfb_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[mmcfb_pkg::CRC_STAGES]),
		.in_ready  (rdy[mmcfb_pkg::CRC_STAGES]),
		.in_item   (item[mmcfb_pkg::CRC_STAGES]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

### rtl/mmcfb_checker.sv
//------------------------------------------------------------------------------
// mmcfb_checker
// Port-level checks on the command frame output stream.
//------------------------------------------------------------------------------
`include "mmc_command_frame_builder_top_defines.svh"

module mmcfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic [2:0] pos_q;
	logic       xfer;

	assign xfer = m_axis_tvalid && m_axis_tready;

	// position of the next output transfer within its frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= mmcfb_pkg::POS_FIRST;
		end else if (xfer) begin
			pos_q <= (pos_q == mmcfb_pkg::POS_LAST) ? mmcfb_pkg::POS_FIRST : pos_q + 1'b1;
		end
	end

	`MMCFB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
	`MMCFB_ASSERT(a_last_pos, clk, arst_n, m_axis_tvalid |-> (m_axis_tlast == (pos_q == mmcfb_pkg::POS_LAST)), "tlast not on seventh byte")
	`MMCFB_ASSERT(a_header, clk, arst_n, (m_axis_tvalid && pos_q == mmcfb_pkg::POS_FIRST) |-> (m_axis_tdata[7:6] == mmcfb_pkg::START_TX_BITS), "bad start/transmission bits")
	`MMCFB_ASSERT(a_crc_end, clk, arst_n, (m_axis_tvalid && pos_q == mmcfb_pkg::POS_CRC) |-> m_axis_tdata[0], "CRC byte end bit missing")
	`MMCFB_ASSERT(a_ctrl, clk, arst_n, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == mmcfb_pkg::CTRL_PLAIN || m_axis_tdata == mmcfb_pkg::CTRL_BLK_READ || m_axis_tdata == mmcfb_pkg::CTRL_BLK_WRITE || m_axis_tdata == mmcfb_pkg::CTRL_REG_READ), "bad control byte")

endmodule

bind mmc_command_frame_builder_top mmcfb_checker u_mmcfb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

### verif/tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the MMC command frame builder. Commands go in on the
// slave stream, every one is predicted as seven frame bytes (start/index byte,
// argument MSB first, CRC7 byte with end bit, control byte) and the master
// stream is compared transfer by transfer. A directed table goes first, then
// random commands with random gaps and stalls and one long output hold-off.
//------------------------------------------------------------------------------
module tb;

	localparam int unsigned IDX_W     = mmcfb_pkg::IDX_W;
	localparam int unsigned ARG_W     = mmcfb_pkg::ARG_W;
	localparam int unsigned CRC_W     = mmcfb_pkg::CRC_W;
	localparam int unsigned BYTE_W    = mmcfb_pkg::BYTE_W;
	localparam int unsigned FRAME_LEN = mmcfb_pkg::FRAME_LEN;
	localparam int unsigned S_TDATA_W = mmcfb_pkg::S_TDATA_W;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_CMDS   = 298;
	localparam int OPEN_CMDS     = 40;      // random commands with no idling at all
	localparam int CHOKE_END     = 70;      // back-to-back commands during the hold-off
	localparam int CHOKE_CYCLES  = 250;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 400000;

	// table entry value meaning "take this byte from the predictor"
	localparam logic [BYTE_W-1:0] FROM_MODEL = 8'h00;

	typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_beat_t;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [ARG_W-1:0]  arg;
		logic [BYTE_W-1:0] crc_byte;
		logic [BYTE_W-1:0] ctrl;
	} cmd_row_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_CHOKE} sink_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [BYTE_W-1:0]    m_axis_tdata;
	logic                 m_axis_tlast;

	frame_beat_t frame_beats_q[$];
	int          mismatches = 0;
	int          cycles = 0;
	sink_mode_t  sink_mode = SINK_RANDOM;

	// directed commands; known CRC bytes typed in for the two classic SD/MMC frames
	cmd_row_t cmd_rows [22] = '{
		'{6'd0,  32'h0000_0000, 8'h95,      mmcfb_pkg::CTRL_PLAIN},
		'{6'd8,  32'h0000_01AA, 8'h87,      mmcfb_pkg::CTRL_PLAIN},
		'{6'd63, 32'hFFFF_FFFF, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd0,  32'hFFFF_FFFF, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd63, 32'h0000_0000, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{mmcfb_pkg::CMD_ALL_SEND_CID, 32'h0000_0000, FROM_MODEL, mmcfb_pkg::CTRL_REG_READ},
		'{mmcfb_pkg::CMD_SEND_CSD,     32'h0001_0000, FROM_MODEL, mmcfb_pkg::CTRL_REG_READ},
		'{mmcfb_pkg::CMD_READ_SINGLE,  32'h0000_0200, FROM_MODEL, mmcfb_pkg::CTRL_BLK_READ},
		'{mmcfb_pkg::CMD_WRITE_BLOCK,  32'hFFFF_FE00, FROM_MODEL, mmcfb_pkg::CTRL_BLK_WRITE},
		'{6'd1,  32'h40FF_8000, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd3,  32'h0000_0000, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd10, 32'h1234_5678, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd16, 32'h0000_0200, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd18, 32'hDEAD_BEEF, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd23, 32'h0000_0001, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd25, 32'h8000_0000, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'h2A, 32'hAAAA_AAAA, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'h15, 32'h5555_5555, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd55, 32'h0000_0000, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd41, 32'h4000_0000, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd58, 32'h0000_0000, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN},
		'{6'd32, 32'h0F0F_F0F0, FROM_MODEL, mmcfb_pkg::CTRL_PLAIN}
	};

	mmc_command_frame_builder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// CRC7 over the 40 message bits, MSB first, zero seed
	function automatic logic [CRC_W-1:0] frame_crc7(input logic [5*BYTE_W-1:0] msg);
		logic [CRC_W-1:0] acc;
		logic             fb;
		acc = '0;
		for (int i = 5 * BYTE_W - 1; i >= 0; i--) begin
			fb  = acc[CRC_W-1] ^ msg[i];
			acc = {acc[CRC_W-2:0], 1'b0};
			if (fb)
				acc = acc ^ mmcfb_pkg::CRC7_POLY;
		end
		return acc;
	endfunction

	function automatic frame_t build_frame(input logic [IDX_W-1:0] idx,
			input logic [ARG_W-1:0] arg);
		frame_t f;
		f[0] = {mmcfb_pkg::START_TX_BITS, idx};
		f[1] = arg[31:24];
		f[2] = arg[23:16];
		f[3] = arg[15:8];
		f[4] = arg[7:0];
		f[5] = {frame_crc7({f[0], f[1], f[2], f[3], f[4]}), 1'b1};
		if (idx == mmcfb_pkg::CMD_ALL_SEND_CID || idx == mmcfb_pkg::CMD_SEND_CSD)
			f[6] = mmcfb_pkg::CTRL_REG_READ;
		else if (idx == mmcfb_pkg::CMD_READ_SINGLE)
			f[6] = mmcfb_pkg::CTRL_BLK_READ;
		else if (idx == mmcfb_pkg::CMD_WRITE_BLOCK)
			f[6] = mmcfb_pkg::CTRL_BLK_WRITE;
		else
			f[6] = mmcfb_pkg::CTRL_PLAIN;
		return f;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 9))
			0: return mmcfb_pkg::CMD_ALL_SEND_CID;
			1: return mmcfb_pkg::CMD_SEND_CSD;
			2: return mmcfb_pkg::CMD_READ_SINGLE;
			3: return mmcfb_pkg::CMD_WRITE_BLOCK;
			default: return IDX_W'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic logic [ARG_W-1:0] pick_argument();
		logic [ARG_W-1:0] one_hot;
		one_hot = ARG_W'(1) << $urandom_range(0, ARG_W - 1);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			default: return $urandom;
		endcase
	endfunction

	// offer one command after a gap, hold it until the transfer, then log its frame
	task automatic send_cmd(input logic [IDX_W-1:0] idx, input logic [ARG_W-1:0] arg,
			input logic [BYTE_W-1:0] crc_byte, input logic [BYTE_W-1:0] ctrl,
			input int gap);
		frame_t f;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = S_TDATA_W'({$urandom, $urandom});
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {2'b00, arg, idx};
		do @(posedge clk); while (!s_axis_tready);
		f = build_frame(idx, arg);
		if (crc_byte != FROM_MODEL)
			f[5] = crc_byte;
		if (ctrl != FROM_MODEL)
			f[6] = ctrl;
		for (int k = 0; k < FRAME_LEN; k++)
			frame_beats_q.push_back('{data: f[k], last: (k == FRAME_LEN - 1)});
	endtask

	// command side
	initial begin : drive_cmds
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (cmd_rows[i])
			send_cmd(cmd_rows[i].idx, cmd_rows[i].arg, cmd_rows[i].crc_byte,
				cmd_rows[i].ctrl, pick_gap());

		sink_mode = SINK_OPEN;
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			// long output hold-off while commands keep coming back to back
			if (i == OPEN_CMDS)
				sink_mode = SINK_CHOKE;
			send_cmd(pick_index(), pick_argument(), FROM_MODEL, FROM_MODEL,
				(i < CHOKE_END) ? 0 : pick_gap());
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		while (frame_beats_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && frame_beats_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// frame side backpressure
	initial begin : drive_sink
		int run;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			case (sink_mode)
				SINK_OPEN: begin
					@(negedge clk);
					m_axis_tready = 1'b1;
				end
				SINK_CHOKE: begin
					@(negedge clk);
					m_axis_tready = 1'b0;
					repeat (CHOKE_CYCLES - 1) @(negedge clk);
					sink_mode = SINK_RANDOM;
				end
				default: begin
					run = $urandom_range(1, 20);
					@(negedge clk);
					m_axis_tready = 1'b1;
					repeat (run - 1) @(negedge clk);
					run = pick_gap();
					if (run > 0) begin
						@(negedge clk);
						m_axis_tready = 1'b0;
						repeat (run - 1) @(negedge clk);
					end
				end
			endcase
		end
	end

	// compare every frame transfer with the oldest expected byte
	always @(posedge clk) begin : check_frame
		frame_beat_t exp_beat;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (frame_beats_q.size() == 0) begin
				$display("%0t: unexpected frame byte, expected none, got data %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				mismatches++;
			end else begin
				exp_beat = frame_beats_q.pop_front();
				if (m_axis_tdata !== exp_beat.data) begin
					$display("%0t: frame byte mismatch, expected %h, got %h",
						$time, exp_beat.data, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tlast !== exp_beat.last) begin
					$display("%0t: tlast mismatch, expected %b, got %b",
						$time, exp_beat.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d frame bytes outstanding",
				$time, frame_beats_q.size());
			$display("Verification failed");
			$finish;
		end
	end

endmodule
